// ===== sv/mtc_pkg.sv =====
// Shared types, constants and codes for the MIDI tempo clock generator.
package mtc_pkg;

  localparam int TS_BITS = 32;
  localparam int PULSES_PER_BEAT_DEF = 24;

  localparam int BPM_W = 9;
  localparam int PERIOD_W = 18;

  localparam int PERIOD_NUM = 2500000;
  localparam int BPM_NUM = 60000;
  localparam int BPM_FLOOR = 10;
  localparam int NUM_W = $clog2(PERIOD_NUM + 1);

  // Command codes
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_EXT_CLOCK = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_CONTINUE = 3'd3;
  localparam logic [2:0] CMD_STOP = 3'd4;
  localparam logic [2:0] CMD_TAP = 3'd5;

  // Tempo source codes
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_EXT = 2'd1;
  localparam logic [1:0] SRC_TAP = 2'd2;

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_BPM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_BPM = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXT_TIMEOUT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LED_PULSE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TAP_WINDOW = 3'd4;
  localparam int PADDR_W = REG_IDX_W + 2;

  // Reset values
  localparam logic [8:0] MIN_BPM_RST = 9'd20;
  localparam logic [8:0] MAX_BPM_RST = 9'd300;
  localparam logic [15:0] EXT_TIMEOUT_RST = 16'd500;
  localparam logic [9:0] LED_PULSE_RST = 10'd40;
  localparam logic [15:0] TAP_WINDOW_RST = 16'd3000;
  localparam logic [BPM_W-1:0] BPM_RST = 9'd120;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 18'd20833;

  typedef struct packed {
    logic [2:0] cmd;
    logic [TS_BITS-1:0] now_us;
    logic [TS_BITS-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic clock_pulse;
    logic beat_led;
    logic [BPM_W-1:0] tempo_bpm;
    logic [1:0] tempo_source;
    logic is_running;
  } result_t;

  typedef struct packed {
    logic [8:0] min_bpm;
    logic [8:0] max_bpm;
    logic [15:0] ext_timeout_ms;
    logic [9:0] led_pulse_ms;
    logic [15:0] tap_window_ms;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [TS_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/mtc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module mtc_div (
  input  logic               clk,
  input  logic               rst,
  input  mtc_pkg::div_req_t  req,
  output mtc_pkg::div_rsp_t  rsp
);

  localparam int NW = mtc_pkg::NUM_W;
  localparam int DW = mtc_pkg::TS_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [DW:0] rem_shift;
  logic        ge;

  assign rem_shift = {rem, q[NW-1]};
  assign ge = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      rem <= ge ? DW'(rem_shift - {1'b0, den}) : rem_shift[DW-1:0];
      q <= {q[NW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

// ===== sv/mtc_regs.sv =====
// APB-style configuration register file.
module mtc_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mtc_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output mtc_pkg::cfg_t                      cfg
);

  logic [mtc_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign idx = paddr[mtc_pkg::PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_bpm <= mtc_pkg::MIN_BPM_RST;
      cfg.max_bpm <= mtc_pkg::MAX_BPM_RST;
      cfg.ext_timeout_ms <= mtc_pkg::EXT_TIMEOUT_RST;
      cfg.led_pulse_ms <= mtc_pkg::LED_PULSE_RST;
      cfg.tap_window_ms <= mtc_pkg::TAP_WINDOW_RST;
    end else if (wr) begin
      unique case (idx)
        mtc_pkg::REG_MIN_BPM:     cfg.min_bpm <= pwdata[8:0];
        mtc_pkg::REG_MAX_BPM:     cfg.max_bpm <= pwdata[8:0];
        mtc_pkg::REG_EXT_TIMEOUT: cfg.ext_timeout_ms <= pwdata[15:0];
        mtc_pkg::REG_LED_PULSE:   cfg.led_pulse_ms <= pwdata[9:0];
        mtc_pkg::REG_TAP_WINDOW:  cfg.tap_window_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mtc_pkg::REG_MIN_BPM:     prdata = {23'd0, cfg.min_bpm};
      mtc_pkg::REG_MAX_BPM:     prdata = {23'd0, cfg.max_bpm};
      mtc_pkg::REG_EXT_TIMEOUT: prdata = {16'd0, cfg.ext_timeout_ms};
      mtc_pkg::REG_LED_PULSE:   prdata = {22'd0, cfg.led_pulse_ms};
      mtc_pkg::REG_TAP_WINDOW:  prdata = {16'd0, cfg.tap_window_ms};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== sv/midi_tempo_clock_generator_top.sv =====
// MIDI tempo clock generator: sequencer, tempo state and result register.
//
//   channel  | signals                          | word
//   ---------+----------------------------------+-----------------------------
//   item     | item_valid, item_stall, item     | cmd, now_us, now_ms
//   result   | result_valid, result_stall, result | pulse, led, bpm, source, run
//   config   | psel, penable, pwrite, paddr, ... | five limit/timing registers
//
// One word at a time: a tick passes S_EXEC, S_SNAP if a pulse is due, S_LED
// and S_OUT; start/continue/stop go from S_EXEC to S_OUT. An external clock
// or tap with an interval runs the shared divider twice (60000/interval,
// then 2500000/bpm); a tempo out of range stops after the first.
// item_stall is high from acceptance until the result is in the output
// register; a stalled result only delays the next acceptance.
// Synchronous reset restores all tempo state and register defaults.
module midi_tempo_clock_generator_top #(
  parameter int PULSES_PER_BEAT = mtc_pkg::PULSES_PER_BEAT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  mtc_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output mtc_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int TW = mtc_pkg::TS_BITS;
  localparam int CNT_W = (PULSES_PER_BEAT > 1) ? $clog2(PULSES_PER_BEAT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PULSES_PER_BEAT - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SNAP = 3'd2;
  localparam logic [2:0] S_LED  = 3'd3;
  localparam logic [2:0] S_DIVB = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DIVP = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  mtc_pkg::cfg_t     cfg;
  mtc_pkg::div_req_t div_req;
  mtc_pkg::div_rsp_t div_rsp;

  mtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic [2:0] state;

  // latched word
  logic [2:0]    cmd;
  logic [TW-1:0] nus;
  logic [TW-1:0] nms;

  // tempo state
  logic [1:0]                   source_sel;
  logic [mtc_pkg::BPM_W-1:0]    bpm_value;
  logic [mtc_pkg::PERIOD_W-1:0] period_us;
  logic [TW-1:0]                next_clock_time_us;
  logic [TW-1:0]                last_external_time_ms;
  logic [CNT_W-1:0]             out_tick_count;
  logic [CNT_W-1:0]             in_tick_count;
  logic [TW-1:0]                last_tap_time_ms;
  logic                         tap_valid;
  logic                         run_flag;
  logic [TW-1:0]                led_off_time_ms;
  logic                         led_level;
  logic [TW-1:0]                last_beat_time_ms;
  logic                         beat_valid;

  logic                         pulse;
  logic                         is_tap;
  logic [mtc_pkg::BPM_W-1:0]    nb;

  logic [TW-1:0]      ext_age;
  logic [TW-1:0]      due_diff;
  logic [TW-1:0]      snap_diff;
  logic [TW-1:0]      led_diff;
  logic [TW-1:0]      beat_iv;
  logic [TW-1:0]      tap_iv;
  logic [TW-1:0]      period_ext;
  logic [CNT_W-1:0]   out_cnt_inc;
  logic [CNT_W-1:0]   in_cnt_inc;
  logic               beat_div;
  logic               tap_div;
  logic               bpm_ok;
  logic               item_acc;
  logic               load_result;

  assign period_ext = TW'(period_us);
  assign ext_age = nms - last_external_time_ms;
  assign due_diff = nus - next_clock_time_us;
  assign snap_diff = nus - next_clock_time_us;
  assign led_diff = nms - led_off_time_ms;
  assign beat_iv = nms - last_beat_time_ms;
  assign tap_iv = nms - last_tap_time_ms;
  assign out_cnt_inc = (out_tick_count == CNT_LAST) ? '0 : out_tick_count + 1'b1;
  assign in_cnt_inc = (in_tick_count == CNT_LAST) ? '0 : in_tick_count + 1'b1;

  assign beat_div = (in_cnt_inc == '0) && beat_valid && (beat_iv != '0);
  assign tap_div = tap_valid && (tap_iv != '0) && (tap_iv < TW'(cfg.tap_window_ms));

  assign bpm_ok = (div_rsp.quot >= mtc_pkg::NUM_W'(mtc_pkg::BPM_FLOOR))
               && (div_rsp.quot >= mtc_pkg::NUM_W'(cfg.min_bpm))
               && (div_rsp.quot <= mtc_pkg::NUM_W'(cfg.max_bpm));

  assign item_stall = (state != S_IDLE);
  assign item_acc = item_valid && !item_stall;
  assign load_result = (state == S_OUT) && (!result_valid || !result_stall);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num = mtc_pkg::NUM_W'(mtc_pkg::BPM_NUM);
    div_req.den = (cmd == mtc_pkg::CMD_TAP) ? tap_iv : beat_iv;
    if (state == S_EXEC) begin
      div_req.start = ((cmd == mtc_pkg::CMD_EXT_CLOCK) && beat_div)
                   || ((cmd == mtc_pkg::CMD_TAP) && tap_div);
    end else if (state == S_CHK) begin
      div_req.start = bpm_ok;
      div_req.num = mtc_pkg::NUM_W'(mtc_pkg::PERIOD_NUM);
      div_req.den = TW'(div_rsp.quot[mtc_pkg::BPM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      cmd <= item.cmd;
      nus <= item.now_us;
      nms <= item.now_ms;
    end
    if (state == S_CHK) begin
      nb <= div_rsp.quot[mtc_pkg::BPM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      source_sel <= mtc_pkg::SRC_NONE;
      bpm_value <= mtc_pkg::BPM_RST;
      period_us <= mtc_pkg::PERIOD_RST;
      next_clock_time_us <= '0;
      last_external_time_ms <= '0;
      out_tick_count <= '0;
      in_tick_count <= '0;
      last_tap_time_ms <= '0;
      tap_valid <= 1'b0;
      run_flag <= 1'b1;
      led_off_time_ms <= '0;
      led_level <= 1'b0;
      last_beat_time_ms <= '0;
      beat_valid <= 1'b0;
      pulse <= 1'b0;
      is_tap <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            pulse <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          case (cmd)
            mtc_pkg::CMD_TICK: begin
              if (source_sel == mtc_pkg::SRC_EXT && ext_age > TW'(cfg.ext_timeout_ms)) begin
                source_sel <= mtc_pkg::SRC_NONE;
              end
              state <= S_LED;
              if (run_flag && !due_diff[TW-1]) begin
                pulse <= 1'b1;
                next_clock_time_us <= next_clock_time_us + period_ext;
                out_tick_count <= out_cnt_inc;
                if (out_cnt_inc == '0) begin
                  led_level <= 1'b1;
                  led_off_time_ms <= nms + TW'(cfg.led_pulse_ms);
                end
                state <= S_SNAP;
              end
            end
            mtc_pkg::CMD_EXT_CLOCK: begin
              in_tick_count <= in_cnt_inc;
              if (in_cnt_inc == '0) begin
                last_beat_time_ms <= nms;
                beat_valid <= 1'b1;
              end
              source_sel <= mtc_pkg::SRC_EXT;
              last_external_time_ms <= nms;
              is_tap <= 1'b0;
              if (beat_div) begin
                state <= S_DIVB;
              end
            end
            mtc_pkg::CMD_START: begin
              out_tick_count <= '0;
              next_clock_time_us <= nus;
              run_flag <= 1'b1;
            end
            mtc_pkg::CMD_CONTINUE: run_flag <= 1'b1;
            mtc_pkg::CMD_STOP: run_flag <= 1'b0;
            mtc_pkg::CMD_TAP: begin
              last_tap_time_ms <= nms;
              tap_valid <= 1'b1;
              is_tap <= 1'b1;
              if (tap_div) begin
                state <= S_DIVB;
              end
            end
            default: ;
          endcase
        end
        S_SNAP: begin
          // fell more than one period behind: restart the schedule from now
          if (!snap_diff[TW-1] && snap_diff > period_ext) begin
            next_clock_time_us <= nus + period_ext;
          end
          state <= S_LED;
        end
        S_LED: begin
          if (led_level && !led_diff[TW-1]) begin
            led_level <= 1'b0;
            led_off_time_ms <= '0;
          end
          state <= S_OUT;
        end
        S_DIVB: begin
          if (div_rsp.done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          // out-of-range tempo: drop it
          state <= bpm_ok ? S_DIVP : S_OUT;
        end
        S_DIVP: begin
          if (div_rsp.done) begin
            bpm_value <= nb;
            period_us <= div_rsp.quot[mtc_pkg::PERIOD_W-1:0];
            if (is_tap) begin
              source_sel <= mtc_pkg::SRC_TAP;
              run_flag <= 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_result) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.clock_pulse <= pulse;
      result.beat_led <= led_level;
      result.tempo_bpm <= bpm_value;
      result.tempo_source <= source_sel;
      result.is_running <= run_flag;
    end
  end

endmodule

// ===== sv/mtc_checker.sv =====
// Port-level checks for the MIDI tempo clock generator, bound to the top level.
module mtc_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input mtc_pkg::result_t result
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item_stall low right after an accepted word");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word dropped or changed");

  a_tempo_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.tempo_bpm >= 9'd10))
    else $error("tempo below floor");

  a_source_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.tempo_source != 2'd3))
    else $error("tempo source out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind midi_tempo_clock_generator_top mtc_checker u_mtc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
